[sv/clock_alarm_setting_controller_defines.svh]
// assertion macros shared by the clock alarm controller
`ifndef CLOCK_ALARM_SETTING_CONTROLLER_DEFINES_SVH
`define CLOCK_ALARM_SETTING_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define CLKALM_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clkalm same-cycle check failed");

// next-cycle implication
`define CLKALM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clkalm next-cycle check failed");

`endif

[sv/clkalm_pkg.sv]
package clkalm_pkg;

   localparam int YEAR_W   = 16;
   localparam int BYTE_W   = 8;
   localparam int CURSOR_W = 4;
   localparam int MODE_W   = 2;
   localparam int NIB_W    = 4;

   typedef logic [CURSOR_W-1:0] cursor_type;
   typedef logic [NIB_W-1:0]    nibble_type;

   // key codes
   localparam logic [BYTE_W-1:0] KEY_LEFT    = 8'h25;
   localparam logic [BYTE_W-1:0] KEY_RIGHT   = 8'h27;
   localparam logic [BYTE_W-1:0] KEY_ENTER   = 8'h0D;
   localparam logic [BYTE_W-1:0] KEY_ESCAPE  = 8'h1B;
   localparam logic [BYTE_W-1:0] KEY_DIGIT_0 = 8'h30;
   localparam logic [BYTE_W-1:0] KEY_DIGIT_9 = 8'h39;

   // alarm after reset
   localparam logic [BYTE_W-1:0] ALARM_HOUR_RST   = 8'h14;
   localparam logic [BYTE_W-1:0] ALARM_MINUTE_RST = 8'h01;

   // result mode codes
   localparam logic [MODE_W-1:0] MODE_CODE_NORMAL    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CODE_SET_TIME  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CODE_SET_ALARM = 2'd2;

   // digit positions in set-time
   localparam cursor_type POS_YEAR_HI   = 4'd0;
   localparam cursor_type POS_YEAR_LO   = 4'd1;
   localparam cursor_type POS_MONTH_HI  = 4'd2;
   localparam cursor_type POS_MONTH_LO  = 4'd3;
   localparam cursor_type POS_DAY_HI    = 4'd4;
   localparam cursor_type POS_DAY_LO    = 4'd5;
   localparam cursor_type POS_WEEKDAY   = 4'd6;
   localparam cursor_type POS_HOUR_HI   = 4'd7;
   localparam cursor_type POS_HOUR_LO   = 4'd8;
   localparam cursor_type POS_MINUTE_HI = 4'd9;
   localparam cursor_type POS_TIME_LAST = 4'd10;

   // digit positions in set-alarm
   localparam cursor_type POS_AL_HOUR_HI   = 4'd0;
   localparam cursor_type POS_AL_HOUR_LO   = 4'd1;
   localparam cursor_type POS_AL_MINUTE_HI = 4'd2;
   localparam cursor_type POS_AL_LAST      = 4'd3;

   localparam cursor_type POS_FIRST = 4'd0;

   typedef enum logic [2:0] {
      MODE_NORMAL    = 3'b001,
      MODE_SET_TIME  = 3'b010,
      MODE_SET_ALARM = 3'b100
   } mode_type;

   typedef struct packed {
      logic              func;
      logic [BYTE_W-1:0] key_code;
      logic [YEAR_W-1:0] cur_year;
      logic [BYTE_W-1:0] cur_month;
      logic [BYTE_W-1:0] cur_day;
      logic [BYTE_W-1:0] cur_weekday;
      logic [BYTE_W-1:0] cur_hour;
      logic [BYTE_W-1:0] cur_minute;
   } req_payload_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      cursor_type        cursor;
      logic              buzzer_on;
      logic              rtc_write;
      logic [YEAR_W-1:0] out_year;
      logic [BYTE_W-1:0] out_month;
      logic [BYTE_W-1:0] out_day;
      logic [BYTE_W-1:0] out_weekday;
      logic [BYTE_W-1:0] out_hour;
      logic [BYTE_W-1:0] out_minute;
      logic [BYTE_W-1:0] alarm_hour_now;
      logic [BYTE_W-1:0] alarm_minute_now;
   } rsp_payload_type;

   function automatic logic [MODE_W-1:0] mode_code(input mode_type m);
      logic [MODE_W-1:0] code;
      unique case (m)
         MODE_NORMAL:   code = MODE_CODE_NORMAL;
         MODE_SET_TIME: code = MODE_CODE_SET_TIME;
         default:       code = MODE_CODE_SET_ALARM;
      endcase
      return code;
   endfunction

endpackage

[sv/clkalm_if.sv]
interface clkalm_req_if import clkalm_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface clkalm_rsp_if import clkalm_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[sv/clock_alarm_setting_controller.sv]
// Clock alarm setting controller. Each item is a key event or an alarm-check tick carrying
// the current BCD time, and each item yields exactly one result item with the mode, the
// cursor, the buzzer level, the active alarm and, on leaving set-time with enter, the edited
// time to write into the clock (those time fields read 0 when rtc_write is low). The block
// takes one item per clock cycle while results are taken; an item waits in the input
// register, and its result is offered from the result register once the item moves there.
// The mode, cursor, edit and alarm registers are updated in the same cycle the item moves
// into the result register, so the next item already sees them. A result that is not
// taken stalls the input register and, behind it, the input channel; there is no start-up
// delay after reset.

`include "clock_alarm_setting_controller_defines.svh"

module clock_alarm_setting_controller
   import clkalm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   clkalm_req_if.sink   req_chan,
   clkalm_rsp_if.source rsp_chan
);

   // pipeline control
   logic            in_valid_ff, in_valid_in;
   logic            out_valid_ff, out_valid_in;
   logic            req_accept;
   logic            advance;
   req_payload_type in_data_ff;
   rsp_payload_type out_data_ff, out_data_in;

   // architectural state
   mode_type          mode_ff, mode_in;
   cursor_type        cursor_ff, cursor_in;
   logic [YEAR_W-1:0] edit_year_ff, edit_year_in;
   logic [BYTE_W-1:0] edit_month_ff, edit_month_in;
   logic [BYTE_W-1:0] edit_day_ff, edit_day_in;
   logic [BYTE_W-1:0] edit_weekday_ff, edit_weekday_in;
   logic [BYTE_W-1:0] edit_hour_ff, edit_hour_in;
   logic [BYTE_W-1:0] edit_minute_ff, edit_minute_in;
   logic [BYTE_W-1:0] alarm_hour_ff, alarm_hour_in;
   logic [BYTE_W-1:0] alarm_minute_ff, alarm_minute_in;
   logic [BYTE_W-1:0] edit_al_hour_ff, edit_al_hour_in;
   logic [BYTE_W-1:0] edit_al_minute_ff, edit_al_minute_in;
   logic              buzzer_ff, buzzer_in;
   logic              mute_ff, mute_in;

   // decode of the item in the input register
   logic       is_digit;
   nibble_type digit;
   logic       alarm_match;
   logic       rtc_wr;
   cursor_type cursor_right;
   cursor_type cursor_left;

   // handshake: the input register moves on whenever the result register is free or drains
   assign advance          = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !in_valid_ff || advance;
   assign req_accept       = req_chan.valid && req_chan.ready;
   assign in_valid_in      = req_accept || (in_valid_ff && !advance);
   assign out_valid_in     = advance || (out_valid_ff && !rsp_chan.ready);
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

   assign is_digit    = (in_data_ff.key_code >= KEY_DIGIT_0) &&
                        (in_data_ff.key_code <= KEY_DIGIT_9);
   assign digit       = in_data_ff.key_code[NIB_W-1:0];
   assign alarm_match = (in_data_ff.cur_hour == alarm_hour_ff) &&
                        (in_data_ff.cur_minute == alarm_minute_ff);

   // cursor moves in the two set modes, wrapping at the last position of the current mode;
   // positions past the end fold back into range
   always_comb begin
      cursor_right = cursor_ff;
      cursor_left  = cursor_ff;
      unique case (mode_ff)
         MODE_NORMAL: begin
            cursor_right = cursor_ff;
            cursor_left  = cursor_ff;
         end
         MODE_SET_TIME: begin
            cursor_right = (cursor_ff < POS_TIME_LAST) ? cursor_ff + 1'b1 : POS_FIRST;
            if (cursor_ff == POS_FIRST) begin
               cursor_left = POS_TIME_LAST;
            end else if (cursor_ff <= POS_TIME_LAST) begin
               cursor_left = cursor_ff - 1'b1;
            end else begin
               cursor_left = POS_MINUTE_HI;
            end
         end
         default: begin
            cursor_right = (cursor_ff < POS_AL_LAST) ? cursor_ff + 1'b1 : POS_FIRST;
            if (cursor_ff == POS_FIRST) begin
               cursor_left = POS_AL_LAST;
            end else if (cursor_ff < POS_AL_LAST) begin
               cursor_left = cursor_ff - 1'b1;
            end else begin
               cursor_left = POS_AL_MINUTE_HI;
            end
         end
      endcase
   end

   // next state for the item in the input register
   always_comb begin
      mode_in           = mode_ff;
      cursor_in         = cursor_ff;
      edit_year_in      = edit_year_ff;
      edit_month_in     = edit_month_ff;
      edit_day_in       = edit_day_ff;
      edit_weekday_in   = edit_weekday_ff;
      edit_hour_in      = edit_hour_ff;
      edit_minute_in    = edit_minute_ff;
      alarm_hour_in     = alarm_hour_ff;
      alarm_minute_in   = alarm_minute_ff;
      edit_al_hour_in   = edit_al_hour_ff;
      edit_al_minute_in = edit_al_minute_ff;
      buzzer_in         = buzzer_ff;
      mute_in           = mute_ff;
      rtc_wr            = 1'b0;

      if (in_data_ff.func) begin
         // alarm-check tick: toggle while matching and not muted, any mismatch re-arms
         if (alarm_match) begin
            buzzer_in = mute_ff ? 1'b0 : !buzzer_ff;
         end else begin
            buzzer_in = 1'b0;
            mute_in   = 1'b0;
         end
      end else if (is_digit) begin
         unique case (mode_ff)
            MODE_NORMAL: begin
               cursor_in = cursor_ff;
            end
            MODE_SET_TIME: begin
               // only the two low year digits are editable, weekday takes its low nibble
               case (cursor_ff)
                  POS_YEAR_HI:   edit_year_in[2*NIB_W-1:NIB_W]  = digit;
                  POS_YEAR_LO:   edit_year_in[NIB_W-1:0]        = digit;
                  POS_MONTH_HI:  edit_month_in[2*NIB_W-1:NIB_W] = digit;
                  POS_MONTH_LO:  edit_month_in[NIB_W-1:0]       = digit;
                  POS_DAY_HI:    edit_day_in[2*NIB_W-1:NIB_W]   = digit;
                  POS_DAY_LO:    edit_day_in[NIB_W-1:0]         = digit;
                  POS_WEEKDAY:   edit_weekday_in[NIB_W-1:0]     = digit;
                  POS_HOUR_HI:   edit_hour_in[2*NIB_W-1:NIB_W]  = digit;
                  POS_HOUR_LO:   edit_hour_in[NIB_W-1:0]        = digit;
                  POS_MINUTE_HI: edit_minute_in[2*NIB_W-1:NIB_W] = digit;
                  default:       edit_minute_in[NIB_W-1:0]      = digit;
               endcase
               cursor_in = cursor_right;
            end
            default: begin
               case (cursor_ff)
                  POS_AL_HOUR_LO:   edit_al_hour_in[NIB_W-1:0]          = digit;
                  POS_AL_HOUR_HI:   edit_al_hour_in[2*NIB_W-1:NIB_W]    = digit;
                  POS_AL_MINUTE_HI: edit_al_minute_in[2*NIB_W-1:NIB_W]  = digit;
                  default:          edit_al_minute_in[NIB_W-1:0]        = digit;
               endcase
               cursor_in = cursor_right;
            end
         endcase
      end else if (in_data_ff.key_code == KEY_LEFT) begin
         cursor_in = cursor_left;
      end else if (in_data_ff.key_code == KEY_RIGHT) begin
         cursor_in = cursor_right;
      end else if (in_data_ff.key_code == KEY_ENTER) begin
         unique case (mode_ff)
            MODE_NORMAL: begin
               // snapshot the running time into the edit buffer
               mode_in         = MODE_SET_TIME;
               edit_year_in    = in_data_ff.cur_year;
               edit_month_in   = in_data_ff.cur_month;
               edit_day_in     = in_data_ff.cur_day;
               edit_weekday_in = in_data_ff.cur_weekday;
               edit_hour_in    = in_data_ff.cur_hour;
               edit_minute_in  = in_data_ff.cur_minute;
               cursor_in       = POS_FIRST;
            end
            MODE_SET_TIME: begin
               // commit the edited time, load the alarm for editing
               mode_in           = MODE_SET_ALARM;
               rtc_wr            = 1'b1;
               edit_al_hour_in   = alarm_hour_ff;
               edit_al_minute_in = alarm_minute_ff;
               cursor_in         = POS_FIRST;
            end
            default: begin
               mode_in         = MODE_NORMAL;
               alarm_hour_in   = edit_al_hour_ff;
               alarm_minute_in = edit_al_minute_ff;
            end
         endcase
      end else if (in_data_ff.key_code == KEY_ESCAPE) begin
         if (mode_ff == MODE_NORMAL) begin
            mute_in = 1'b1;
         end else begin
            mode_in = MODE_NORMAL;
         end
      end
   end

   // result item
   always_comb begin
      out_data_in                  = '0;
      out_data_in.mode             = mode_code(mode_in);
      out_data_in.cursor           = cursor_in;
      out_data_in.buzzer_on        = buzzer_in;
      out_data_in.rtc_write        = rtc_wr;
      out_data_in.alarm_hour_now   = alarm_hour_in;
      out_data_in.alarm_minute_now = alarm_minute_in;
      if (rtc_wr) begin
         out_data_in.out_year    = edit_year_in;
         out_data_in.out_month   = edit_month_in;
         out_data_in.out_day     = edit_day_in;
         out_data_in.out_weekday = edit_weekday_in;
         out_data_in.out_hour    = edit_hour_in;
         out_data_in.out_minute  = edit_minute_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_chan.payload;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         mode_ff           <= MODE_NORMAL;
         cursor_ff         <= POS_FIRST;
         edit_year_ff      <= '0;
         edit_month_ff     <= '0;
         edit_day_ff       <= '0;
         edit_weekday_ff   <= '0;
         edit_hour_ff      <= '0;
         edit_minute_ff    <= '0;
         alarm_hour_ff     <= ALARM_HOUR_RST;
         alarm_minute_ff   <= ALARM_MINUTE_RST;
         edit_al_hour_ff   <= '0;
         edit_al_minute_ff <= '0;
         buzzer_ff         <= 1'b0;
         mute_ff           <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            mode_ff           <= mode_in;
            cursor_ff         <= cursor_in;
            edit_year_ff      <= edit_year_in;
            edit_month_ff     <= edit_month_in;
            edit_day_ff       <= edit_day_in;
            edit_weekday_ff   <= edit_weekday_in;
            edit_hour_ff      <= edit_hour_in;
            edit_minute_ff    <= edit_minute_in;
            alarm_hour_ff     <= alarm_hour_in;
            alarm_minute_ff   <= alarm_minute_in;
            edit_al_hour_ff   <= edit_al_hour_in;
            edit_al_minute_ff <= edit_al_minute_in;
            buzzer_ff         <= buzzer_in;
            mute_ff           <= mute_in;
         end
      end
   end

   // a commit only happens on the step into set-alarm
   `CLKALM_ASSERT_NOW(a_commit_mode, clock, reset,
      out_valid_ff && out_data_ff.rtc_write,
      out_data_ff.mode == MODE_CODE_SET_ALARM)

   // without a commit the edited time fields stay zero
   `CLKALM_ASSERT_NOW(a_no_commit_zero, clock, reset,
      out_valid_ff && !out_data_ff.rtc_write,
      (out_data_ff.out_year == '0) && (out_data_ff.out_minute == '0))

   // a stalled result freezes the mode and cursor registers
   `CLKALM_ASSERT_NEXT(a_stall_holds_state, clock, reset,
      out_valid_ff && !rsp_chan.ready,
      $stable(mode_ff) && $stable(cursor_ff))

endmodule

[verif/tb.sv]
module tb;
   import clkalm_pkg::*;

   // run length and throttling
   localparam int ITEMS_PER_PHASE = 266;
   localparam int NUM_PHASES      = 5;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 8;

   // one row of the directed script
   typedef struct {
      req_payload_type stim;
      logic            checked;
      rsp_payload_type want;
   } script_row_type;

   logic clock;
   logic reset;

   clkalm_req_if req_if ();
   clkalm_rsp_if rsp_if ();

   // typed-in expectation travels next to the item it belongs to
   logic            typed_valid;
   rsp_payload_type typed_status;

   clock_alarm_setting_controller dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // controller shadow state
   mode_type    mode_now;
   logic [7:0]  cursor_pos;
   logic [15:0] ed_year;
   logic [7:0]  ed_month, ed_day, ed_weekday, ed_hour, ed_minute;
   logic [7:0]  alarm_hr, alarm_mn, ed_alarm_hr, ed_alarm_mn;
   logic        buzz, muted;

   rsp_payload_type pending_status[$];
   script_row_type  script[$];

   int unsigned src_idle_pct;
   int unsigned sink_stall_pct;
   int unsigned cycle_count = 0;
   int unsigned error_count;
   int unsigned items_sent;
   int unsigned random_items;
   int unsigned results_seen;
   int unsigned commits_seen;
   int unsigned buzz_seen;

   // clock and the single reset pulse
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_status.size());
      $display("*** FAILED ***");
      $finish;
   end

   // result side backpressure, one decision per falling edge
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   // ---------------------------------------------------------------
   // shadow model of the controller
   // ---------------------------------------------------------------

   function void clear_shadow();
      mode_now    = MODE_NORMAL;
      cursor_pos  = '0;
      ed_year     = '0;
      ed_month    = '0;
      ed_day      = '0;
      ed_weekday  = '0;
      ed_hour     = '0;
      ed_minute   = '0;
      alarm_hr    = ALARM_HOUR_RST;
      alarm_mn    = ALARM_MINUTE_RST;
      ed_alarm_hr = '0;
      ed_alarm_mn = '0;
      buzz        = 1'b0;
      muted       = 1'b0;
   endfunction

   // cursor moves wrap; normal mode leaves the cursor alone
   function void cursor_right();
      if (mode_now == MODE_SET_TIME)
         cursor_pos = (cursor_pos < POS_TIME_LAST) ? cursor_pos + 8'd1 : 8'(POS_FIRST);
      else if (mode_now != MODE_NORMAL)
         cursor_pos = (cursor_pos < POS_AL_LAST) ? cursor_pos + 8'd1 : 8'(POS_FIRST);
   endfunction

   function void cursor_left();
      if (mode_now == MODE_SET_TIME) begin
         if (cursor_pos == POS_FIRST)          cursor_pos = 8'(POS_TIME_LAST);
         else if (cursor_pos <= POS_TIME_LAST) cursor_pos = cursor_pos - 8'd1;
         else                                  cursor_pos = 8'(POS_MINUTE_HI);
      end else if (mode_now != MODE_NORMAL) begin
         if (cursor_pos == POS_FIRST)        cursor_pos = 8'(POS_AL_LAST);
         else if (cursor_pos < POS_AL_LAST)  cursor_pos = cursor_pos - 8'd1;
         else                                cursor_pos = 8'(POS_AL_MINUTE_HI);
      end
   endfunction

   // in the set modes a digit overwrites the nibble under the cursor, then steps right
   function void write_digit(input nibble_type d);
      if (mode_now == MODE_SET_TIME) begin
         case (cursor_pos)
            POS_YEAR_HI:   ed_year[7:4]    = d;
            POS_YEAR_LO:   ed_year[3:0]    = d;
            POS_MONTH_HI:  ed_month[7:4]   = d;
            POS_MONTH_LO:  ed_month[3:0]   = d;
            POS_DAY_HI:    ed_day[7:4]     = d;
            POS_DAY_LO:    ed_day[3:0]     = d;
            POS_WEEKDAY:   ed_weekday[3:0] = d;
            POS_HOUR_HI:   ed_hour[7:4]    = d;
            POS_HOUR_LO:   ed_hour[3:0]    = d;
            POS_MINUTE_HI: ed_minute[7:4]  = d;
            default:       ed_minute[3:0]  = d;
         endcase
         cursor_right();
      end else if (mode_now != MODE_NORMAL) begin
         case (cursor_pos)
            POS_AL_HOUR_HI:   ed_alarm_hr[7:4] = d;
            POS_AL_HOUR_LO:   ed_alarm_hr[3:0] = d;
            POS_AL_MINUTE_HI: ed_alarm_mn[7:4] = d;
            default:          ed_alarm_mn[3:0] = d;
         endcase
         cursor_right();
      end
   endfunction

   // one item in, the status it produces out
   function void compute_status(input req_payload_type r, output rsp_payload_type s);
      logic commit;
      commit = 1'b0;
      if (r.func) begin
         if (r.cur_hour == alarm_hr && r.cur_minute == alarm_mn) begin
            buzz = muted ? 1'b0 : ~buzz;
         end else begin
            muted = 1'b0;
            buzz  = 1'b0;
         end
      end else if (r.key_code >= KEY_DIGIT_0 && r.key_code <= KEY_DIGIT_9) begin
         write_digit(nibble_type'(r.key_code - KEY_DIGIT_0));
      end else if (r.key_code == KEY_LEFT) begin
         cursor_left();
      end else if (r.key_code == KEY_RIGHT) begin
         cursor_right();
      end else if (r.key_code == KEY_ENTER) begin
         case (mode_now)
            MODE_NORMAL: begin
               // snapshot the running time into the edit buffer
               mode_now   = MODE_SET_TIME;
               ed_year    = r.cur_year;
               ed_month   = r.cur_month;
               ed_day     = r.cur_day;
               ed_weekday = r.cur_weekday;
               ed_hour    = r.cur_hour;
               ed_minute  = r.cur_minute;
               cursor_pos = 8'(POS_FIRST);
            end
            MODE_SET_TIME: begin
               mode_now    = MODE_SET_ALARM;
               commit      = 1'b1;
               ed_alarm_hr = alarm_hr;
               ed_alarm_mn = alarm_mn;
               cursor_pos  = 8'(POS_FIRST);
            end
            default: begin
               mode_now = MODE_NORMAL;
               alarm_hr = ed_alarm_hr;
               alarm_mn = ed_alarm_mn;
            end
         endcase
      end else if (r.key_code == KEY_ESCAPE) begin
         if (mode_now == MODE_NORMAL) muted = 1'b1;
         else mode_now = MODE_NORMAL;
      end

      s = '0;
      case (mode_now)
         MODE_NORMAL:   s.mode = MODE_CODE_NORMAL;
         MODE_SET_TIME: s.mode = MODE_CODE_SET_TIME;
         default:       s.mode = MODE_CODE_SET_ALARM;
      endcase
      s.cursor    = cursor_pos[3:0];
      s.buzzer_on = buzz;
      s.rtc_write = commit;
      // edited time only shows on a commit
      if (commit) begin
         s.out_year    = ed_year;
         s.out_month   = ed_month;
         s.out_day     = ed_day;
         s.out_weekday = ed_weekday;
         s.out_hour    = ed_hour;
         s.out_minute  = ed_minute;
      end
      s.alarm_hour_now   = alarm_hr;
      s.alarm_minute_now = alarm_mn;
   endfunction

   // ---------------------------------------------------------------
   // scoreboard
   // ---------------------------------------------------------------

   function void check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   function void check_status(input rsp_payload_type w, input rsp_payload_type g);
      check_field("mode",             w.mode,             g.mode);
      check_field("cursor",           w.cursor,           g.cursor);
      check_field("buzzer_on",        w.buzzer_on,        g.buzzer_on);
      check_field("rtc_write",        w.rtc_write,        g.rtc_write);
      check_field("out_year",         w.out_year,         g.out_year);
      check_field("out_month",        w.out_month,        g.out_month);
      check_field("out_day",          w.out_day,          g.out_day);
      check_field("out_weekday",      w.out_weekday,      g.out_weekday);
      check_field("out_hour",         w.out_hour,         g.out_hour);
      check_field("out_minute",       w.out_minute,       g.out_minute);
      check_field("alarm_hour_now",   w.alarm_hour_now,   g.alarm_hour_now);
      check_field("alarm_minute_now", w.alarm_minute_now, g.alarm_minute_now);
   endfunction

   // accepted items feed the shadow model, accepted results pop the oldest expectation
   always @(posedge clock) begin : scoreboard
      rsp_payload_type calc;
      rsp_payload_type want;
      if (reset) begin
         clear_shadow();
      end else begin
         if (req_if.valid && req_if.ready) begin
            compute_status(req_if.payload, calc);
            // checked directed rows carry their own hand-written status
            pending_status.push_back(typed_valid ? typed_status : calc);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_status.size() == 0) begin
               $error("result item arrived with nothing outstanding");
               error_count++;
            end else begin
               want = pending_status.pop_front();
               check_status(want, rsp_if.payload);
               results_seen++;
               if (rsp_if.payload.rtc_write) commits_seen++;
               if (rsp_if.payload.buzzer_on) buzz_seen++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------

   // drive at the falling edge, hold until accepted at a rising edge;
   // a hit tick takes hour and minute from the alarm that is active right now
   task automatic push_request(input req_payload_type item, input bit hit,
                               input bit has_want, input rsp_payload_type want);
      @(negedge clock);
      while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      if (hit) begin
         item.cur_hour   = alarm_hr;
         item.cur_minute = alarm_mn;
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      typed_valid    <= has_want;
      typed_status   <= want;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   function automatic req_payload_type random_fields();
      req_payload_type it;
      it.func        = 1'($urandom_range(1));
      it.key_code    = 8'($urandom_range(255));
      it.cur_year    = 16'($urandom);
      it.cur_month   = 8'($urandom);
      it.cur_day     = 8'($urandom);
      it.cur_weekday = 8'($urandom);
      it.cur_hour    = 8'($urandom);
      it.cur_minute  = 8'($urandom);
      return it;
   endfunction

   function automatic req_payload_type key_item(input logic [7:0] code);
      req_payload_type it;
      it          = '0;
      it.key_code = code;
      return it;
   endfunction

   function automatic req_payload_type tick_item(input logic [7:0] hr, input logic [7:0] mn,
                                                 input logic [7:0] code);
      req_payload_type it;
      it            = '0;
      it.func       = 1'b1;
      it.key_code   = code;
      it.cur_year   = 16'h2024;
      it.cur_hour   = hr;
      it.cur_minute = mn;
      return it;
   endfunction

   // enter key with every time field set to one byte pattern
   function automatic req_payload_type snap_item(input logic [7:0] v);
      req_payload_type it;
      it.func        = 1'b0;
      it.key_code    = KEY_ENTER;
      it.cur_year    = {v, v};
      it.cur_month   = v;
      it.cur_day     = v;
      it.cur_weekday = v;
      it.cur_hour    = v;
      it.cur_minute  = v;
      return it;
   endfunction

   // status with no commit
   function automatic rsp_payload_type plain_status(input logic [1:0] md, input cursor_type cur,
                                                    input logic bz, input logic [7:0] ah,
                                                    input logic [7:0] am);
      rsp_payload_type s;
      s                  = '0;
      s.mode             = md;
      s.cursor           = cur;
      s.buzzer_on        = bz;
      s.alarm_hour_now   = ah;
      s.alarm_minute_now = am;
      return s;
   endfunction

   task automatic add_row(input req_payload_type stim, input logic checked,
                          input rsp_payload_type want);
      script.push_back('{stim: stim, checked: checked, want: want});
   endtask

   task automatic build_script();
      rsp_payload_type cw;
      // buzzer toggles on matching ticks with the reset alarm
      add_row(tick_item(8'h14, 8'h01, 8'h00), 1,
              plain_status(MODE_CODE_NORMAL, POS_FIRST, 1'b1, 8'h14, 8'h01));
      add_row(tick_item(8'h14, 8'h01, 8'h00), 1,
              plain_status(MODE_CODE_NORMAL, POS_FIRST, 1'b0, 8'h14, 8'h01));
      add_row(tick_item(8'h14, 8'h01, 8'h00), 1,
              plain_status(MODE_CODE_NORMAL, POS_FIRST, 1'b1, 8'h14, 8'h01));
      // escape in normal mode mutes, buzzer holds until the next match
      add_row(key_item(KEY_ESCAPE), 1,
              plain_status(MODE_CODE_NORMAL, POS_FIRST, 1'b1, 8'h14, 8'h01));
      add_row(tick_item(8'h14, 8'h01, 8'h00), 1,
              plain_status(MODE_CODE_NORMAL, POS_FIRST, 1'b0, 8'h14, 8'h01));
      // mismatch clears the mute
      add_row(tick_item(8'hFF, 8'hFF, 8'h00), 1,
              plain_status(MODE_CODE_NORMAL, POS_FIRST, 1'b0, 8'h14, 8'h01));
      add_row(tick_item(8'h14, 8'h01, 8'h00), 1,
              plain_status(MODE_CODE_NORMAL, POS_FIRST, 1'b1, 8'h14, 8'h01));
      // editing keys and unknown codes do nothing in normal mode
      add_row(key_item(KEY_DIGIT_0 + 8'd5), 1,
              plain_status(MODE_CODE_NORMAL, POS_FIRST, 1'b1, 8'h14, 8'h01));
      add_row(key_item(KEY_LEFT), 1,
              plain_status(MODE_CODE_NORMAL, POS_FIRST, 1'b1, 8'h14, 8'h01));
      add_row(key_item(8'hFF), 1,
              plain_status(MODE_CODE_NORMAL, POS_FIRST, 1'b1, 8'h14, 8'h01));
      // tick ignores its key code, minute-only mismatch clears the buzzer
      add_row(tick_item(8'h14, 8'h02, KEY_ENTER), 1,
              plain_status(MODE_CODE_NORMAL, POS_FIRST, 1'b0, 8'h14, 8'h01));
      // set-time from an all-ones clock, wrap both ways, then cancel
      add_row(snap_item(8'hFF), 1,
              plain_status(MODE_CODE_SET_TIME, POS_FIRST, 1'b0, 8'h14, 8'h01));
      add_row(key_item(KEY_LEFT), 1,
              plain_status(MODE_CODE_SET_TIME, POS_TIME_LAST, 1'b0, 8'h14, 8'h01));
      add_row(key_item(KEY_DIGIT_9), 1,
              plain_status(MODE_CODE_SET_TIME, POS_FIRST, 1'b0, 8'h14, 8'h01));
      add_row(key_item(KEY_RIGHT), 1,
              plain_status(MODE_CODE_SET_TIME, POS_YEAR_LO, 1'b0, 8'h14, 8'h01));
      add_row(key_item(KEY_DIGIT_0), 1,
              plain_status(MODE_CODE_SET_TIME, POS_MONTH_HI, 1'b0, 8'h14, 8'h01));
      add_row(key_item(KEY_ESCAPE), 1,
              plain_status(MODE_CODE_NORMAL, POS_MONTH_HI, 1'b0, 8'h14, 8'h01));
      // set-time from an all-zero clock, edit year and month, commit
      add_row(snap_item(8'h00), 1,
              plain_status(MODE_CODE_SET_TIME, POS_FIRST, 1'b0, 8'h14, 8'h01));
      add_row(key_item(KEY_DIGIT_9), 0, '0);
      add_row(key_item(KEY_DIGIT_9), 0, '0);
      add_row(key_item(KEY_DIGIT_0 + 8'd1), 0, '0);
      cw           = plain_status(MODE_CODE_SET_ALARM, POS_FIRST, 1'b0, 8'h14, 8'h01);
      cw.rtc_write = 1'b1;
      cw.out_year  = 16'h0099;
      cw.out_month = 8'h10;
      add_row(key_item(KEY_ENTER), 1, cw);
      // set-alarm: wrap left, edit last nibble, wrap right, activate
      add_row(key_item(KEY_LEFT), 1,
              plain_status(MODE_CODE_SET_ALARM, POS_AL_LAST, 1'b0, 8'h14, 8'h01));
      add_row(key_item(KEY_DIGIT_0 + 8'd7), 1,
              plain_status(MODE_CODE_SET_ALARM, POS_FIRST, 1'b0, 8'h14, 8'h01));
      add_row(key_item(KEY_ENTER), 1,
              plain_status(MODE_CODE_NORMAL, POS_FIRST, 1'b0, 8'h14, 8'h07));
   endtask

   // editing keys, mostly digits, a few cursor moves, unknown codes and ticks
   task automatic send_edit_key();
      req_payload_type it;
      int unsigned     r;
      it      = random_fields();
      it.func = 1'b0;
      r       = $urandom_range(99);
      if (r < 68)      it.key_code = KEY_DIGIT_0 + 8'($urandom_range(9));
      else if (r < 80) it.key_code = KEY_LEFT;
      else if (r < 92) it.key_code = KEY_RIGHT;
      else if (r < 96) it.key_code = 8'($urandom_range(8'h40, 8'hFF));
      else             it.func     = 1'b1;
      push_request(it, 1'b0, 1'b0, '0);
      random_items++;
   endtask

   task automatic send_key(input logic [7:0] code);
      req_payload_type it;
      it          = random_fields();
      it.func     = 1'b0;
      it.key_code = code;
      push_request(it, 1'b0, 1'b0, '0);
      random_items++;
   endtask

   // full edit pass: snapshot, edit time, commit or cancel, and after a commit edit alarm, activate or cancel
   task automatic run_edit_session();
      req_payload_type it;
      int unsigned     n;
      if ($urandom_range(1)) send_key(KEY_ESCAPE);
      it = random_fields();
      if ($urandom_range(1)) begin
         // plausible bcd snapshot
         it.cur_hour   = {4'($urandom_range(2)), 4'($urandom_range(9))};
         it.cur_minute = {4'($urandom_range(5)), 4'($urandom_range(9))};
         it.cur_month  = {4'($urandom_range(1)), 4'($urandom_range(9))};
      end
      it.func     = 1'b0;
      it.key_code = KEY_ENTER;
      push_request(it, 1'b0, 1'b0, '0);
      random_items++;
      n = $urandom_range(14);
      repeat (n) send_edit_key();
      if ($urandom_range(9) == 0) begin
         send_key(KEY_ESCAPE);
      end else begin
         send_key(KEY_ENTER);
         n = $urandom_range(6);
         repeat (n) send_edit_key();
         send_key(($urandom_range(9) == 0) ? KEY_ESCAPE : KEY_ENTER);
      end
   endtask

   // ticks against the live alarm, some misses and mutes mixed in
   task automatic run_tick_burst();
      req_payload_type it;
      int unsigned     n;
      int unsigned     r;
      n = $urandom_range(1, 10);
      repeat (n) begin
         r = $urandom_range(99);
         if (r < 90) begin
            it      = random_fields();
            it.func = 1'b1;
            push_request(it, r < 75, 1'b0, '0);
            random_items++;
         end else begin
            send_key(KEY_ESCAPE);
         end
      end
   endtask

   // anything at all; only items the block reacts to count toward the run
   task automatic run_noise();
      req_payload_type it;
      int unsigned     n;
      logic            reacts;
      n = $urandom_range(1, 6);
      repeat (n) begin
         it = random_fields();
         if ($urandom_range(9) < 3) begin
            case ($urandom_range(3))
               0:       it.key_code = KEY_LEFT;
               1:       it.key_code = KEY_RIGHT;
               2:       it.key_code = KEY_ENTER;
               default: it.key_code = KEY_ESCAPE;
            endcase
         end
         reacts = it.func || it.key_code == KEY_LEFT || it.key_code == KEY_RIGHT
                  || it.key_code == KEY_ENTER || it.key_code == KEY_ESCAPE
                  || (it.key_code >= KEY_DIGIT_0 && it.key_code <= KEY_DIGIT_9);
         push_request(it, 1'b0, 1'b0, '0);
         if (reacts) random_items++;
      end
   endtask

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------

   initial begin : main
      int unsigned src_pct[NUM_PHASES];
      int unsigned sink_pct[NUM_PHASES];
      int unsigned r;
      src_pct  = '{0, 76, 0, 11, 0};
      sink_pct = '{0, 0, 76, 11, 0};
      error_count    = 0;
      items_sent     = 0;
      random_items   = 0;
      results_seen   = 0;
      commits_seen   = 0;
      buzz_seen      = 0;
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      typed_valid    = 1'b0;
      typed_status   = '0;

      build_script();
      @(negedge reset);

      // directed script at full rate
      foreach (script[i])
         push_request(script[i].stim, 1'b0, script[i].checked, script[i].want);

      // random episodes, one throttling pattern per phase
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         src_idle_pct   = src_pct[ph];
         sink_stall_pct = sink_pct[ph];
         while (random_items < (ph + 1) * ITEMS_PER_PHASE) begin
            r = $urandom_range(99);
            if (r < 45)      run_edit_session();
            else if (r < 80) run_tick_burst();
            else             run_noise();
         end
      end

      // stop sending, let every result drain
      @(negedge clock);
      req_if.valid   <= 1'b0;
      typed_valid    <= 1'b0;
      sink_stall_pct = 0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d items sent (%0d directed), %0d results checked", items_sent,
               script.size(), results_seen);
      $display("%0d clock commits and %0d buzzer-on results seen over five throttling phases",
               commits_seen, buzz_seen);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
